/* rtl/container_text_quote_normalizer_macros.svh */
// Assertion macros shared by the quote normalizer RTL
`ifndef CONTAINER_TEXT_QUOTE_NORMALIZER_MACROS_SVH
`define CONTAINER_TEXT_QUOTE_NORMALIZER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define QN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define QN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/qn_pkg.sv */
`default_nettype none

package qn_pkg;

    // Rewrite mode codes (mode 3 falls under object rules)
    localparam logic [1:0] MODE_MAP  = 2'd0;
    localparam logic [1:0] MODE_CONT = 2'd1;
    localparam logic [1:0] MODE_OBJ  = 2'd2;

    // Character codes
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_QUOTE  = 8'h27;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;

    // Most characters one input can expand into
    localparam int unsigned MAX_CHARS = 4;

    // Parser flags
    typedef struct packed {
        logic skip_blanks;
        logic quote_open;
        logic paren_open;
        logic token_pending;
        logic error_latched;
    } t_flags;

    // One input's worth of output characters, first at index 0
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                last_idx;
        logic                      bad;
    } t_burst;

endpackage

`default_nettype wire

/* rtl/container_text_quote_normalizer.sv */
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_ch, i_first_char
// output    out        o_valid / i_stall         o_out_char, o_run_last, o_bad_object
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (rewrite mode)
//
// One input character per cycle is taken while the burst queue has room; each
// yields zero to four output characters, sent one per cycle from the back end while i_stall is low.
// The first output character passes through the burst queue, the working burst and the output register.
// Sustained rate is set by the output port: one character per cycle while i_stall is low.
// Reset is synchronous: mode goes to map rules, flags clear but skip_blanks sets, queue empties.
// o_stall rises only when the burst queue is full; config is always ready.

`default_nettype none

module container_text_quote_normalizer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_first_char,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_run_last,
    output logic            o_bad_object
);
    import qn_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    t_burst q_in;
    t_burst q_out;

    assign o_cfg_ready = 1'b1;

    // Front end: classify characters, track flags
    qn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_ch         (i_ch),
        .i_first_char (i_first_char),
        .i_q_full     (q_full),
        .o_stall      (o_stall),
        .o_push       (q_push),
        .o_burst      (q_in)
    );

    // Burst queue between front and back
    qn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Back end: serialize bursts to the output
    qn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_out),
        .o_pop        (q_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_bad_object (o_bad_object)
    );

endmodule

`default_nettype wire

/* rtl/qn_front.sv */
`default_nettype none

module qn_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_data,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_first_char,
    input  wire logic          i_q_full,
    output logic               o_stall,
    output logic               o_push,
    output qn_pkg::t_burst     o_burst
);
    import qn_pkg::*;

    logic [1:0] r_mode;
    t_flags     r_flags;
    t_flags     n_flags;
    t_flags     f;
    logic       accept;
    logic       is_map;
    logic       is_obj;
    logic [2:0] cnt;
    logic [MAX_CHARS-1:0][7:0] chars;
    logic       bad;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign is_map  = (r_mode == MODE_MAP);
    assign is_obj  = r_mode[1];

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MAP;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Classify the character and update flags
    always_comb begin
        f = r_flags;
        if (i_first_char) begin
            f = '{skip_blanks: 1'b1, quote_open: 1'b0, paren_open: 1'b0,
                  token_pending: 1'b0, error_latched: 1'b0};
        end
        n_flags = f;
        cnt     = 3'd0;
        chars   = '0;
        bad     = 1'b0;
        if (!f.error_latched && i_ch != C_NUL) begin
            if (is_obj) begin
                if (i_ch == C_QUOTE) begin
                    n_flags.error_latched = 1'b1;
                    bad = 1'b1;
                    cnt = 3'd1;
                end else begin
                    case (i_ch)
                        C_COMMA: begin
                            chars[0] = C_QUOTE; chars[1] = C_COMMA; chars[2] = C_QUOTE;
                            cnt = 3'd3;
                        end
                        C_LPAREN, C_LBRACK: begin
                            chars[0] = C_LBRACK; chars[1] = C_QUOTE;
                            cnt = 3'd2;
                        end
                        C_RPAREN, C_RBRACK: begin
                            chars[0] = C_QUOTE; chars[1] = C_RBRACK;
                            cnt = 3'd2;
                        end
                        default: begin
                            chars[0] = i_ch;
                            cnt = 3'd1;
                        end
                    endcase
                end
            end else begin
                case (i_ch)
                    C_QUOTE: begin
                        chars[0] = C_QUOTE;
                        cnt = 3'd1;
                        n_flags.token_pending = 1'b0;
                        n_flags.quote_open    = 1'b0;
                    end
                    C_COLON: begin
                        if (f.quote_open) begin
                            chars[0] = C_QUOTE; chars[1] = C_COLON;
                            chars[2] = C_SPACE; chars[3] = C_QUOTE;
                            cnt = 3'd4;
                        end else begin
                            chars[0] = C_COLON; chars[1] = C_SPACE; chars[2] = C_QUOTE;
                            cnt = 3'd3;
                        end
                        n_flags.quote_open  = 1'b1;
                        n_flags.skip_blanks = 1'b1;
                    end
                    C_COMMA: begin
                        // comma inside map parentheses keeps the quote open
                        if (f.quote_open && !(is_map && f.paren_open)) begin
                            chars[0] = C_QUOTE; chars[1] = C_COMMA;
                            cnt = 3'd2;
                            n_flags.quote_open = 1'b0;
                        end else begin
                            chars[0] = C_COMMA;
                            cnt = 3'd1;
                        end
                        n_flags.token_pending = 1'b1;
                        n_flags.skip_blanks   = 1'b1;
                    end
                    C_LPAREN: begin
                        chars[0] = C_LPAREN;
                        cnt = 3'd1;
                        if (is_map) begin
                            n_flags.paren_open = 1'b1;
                        end else begin
                            n_flags.token_pending = 1'b1;
                            n_flags.skip_blanks   = 1'b1;
                        end
                    end
                    C_RPAREN: begin
                        if (is_map) begin
                            chars[0] = C_RPAREN;
                            cnt = 3'd1;
                            n_flags.paren_open = 1'b0;
                        end else if (f.quote_open) begin
                            chars[0] = C_QUOTE; chars[1] = C_RPAREN;
                            cnt = 3'd2;
                            n_flags.quote_open = 1'b0;
                        end else begin
                            chars[0] = C_RPAREN;
                            cnt = 3'd1;
                        end
                    end
                    C_LBRACK, C_LBRACE: begin
                        chars[0] = i_ch;
                        cnt = 3'd1;
                        n_flags.token_pending = 1'b1;
                        n_flags.skip_blanks   = 1'b1;
                    end
                    C_RBRACK, C_RBRACE: begin
                        if (f.quote_open) begin
                            chars[0] = C_QUOTE; chars[1] = i_ch;
                            cnt = 3'd2;
                            n_flags.quote_open = 1'b0;
                        end else begin
                            chars[0] = i_ch;
                            cnt = 3'd1;
                        end
                    end
                    C_SPACE: begin
                        if (!f.skip_blanks) begin
                            chars[0] = C_SPACE;
                            cnt = 3'd1;
                        end
                    end
                    default: begin
                        // ordinary character, may open a token
                        if (f.token_pending && !(is_map && f.paren_open)) begin
                            chars[0] = C_QUOTE; chars[1] = i_ch;
                            cnt = 3'd2;
                        end else begin
                            chars[0] = i_ch;
                            cnt = 3'd1;
                        end
                        if (f.token_pending) begin
                            n_flags.token_pending = 1'b0;
                            n_flags.quote_open    = 1'b1;
                        end
                        n_flags.skip_blanks = 1'b0;
                    end
                endcase
            end
        end
    end

    // Flag register, updated only on accepted requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '{skip_blanks: 1'b1, quote_open: 1'b0, paren_open: 1'b0,
                         token_pending: 1'b0, error_latched: 1'b0};
        end else if (accept) begin
            r_flags <= n_flags;
        end
    end

    assign o_push           = accept && (cnt != 3'd0);
    assign o_burst.chars    = chars;
    assign o_burst.last_idx = 2'(cnt - 3'd1);
    assign o_burst.bad      = bad;

endmodule

`default_nettype wire

/* rtl/qn_queue.sv */
`default_nettype none

`include "container_text_quote_normalizer_macros.svh"

module qn_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  qn_pkg::t_burst i_data,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_valid,
    output qn_pkg::t_burst o_data
);
    import qn_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_burst          r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `QN_ASSERT_NOW(a_no_overflow, i_push, !o_full, "queue push while full")
    `QN_ASSERT_NOW(a_no_underflow, i_pop, o_valid, "queue pop while empty")

endmodule

`default_nettype wire

/* rtl/qn_back.sv */
`default_nettype none

`include "container_text_quote_normalizer_macros.svh"

module qn_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_valid,
    input  qn_pkg::t_burst i_q_data,
    output logic           o_pop,
    input  wire logic      i_stall,
    output logic           o_valid,
    output logic [7:0]     o_out_char,
    output logic           o_run_last,
    output logic           o_bad_object
);
    import qn_pkg::*;

    t_burst     r_burst;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       r_ovalid;
    logic [7:0] r_ochar;
    logic       r_olast;
    logic       r_obad;
    logic       adv;
    logic       at_last;

    // Move one character to the output register when it is free
    assign adv     = r_busy && (!r_ovalid || !i_stall);
    assign at_last = (r_idx == r_burst.last_idx);
    assign o_pop   = i_q_valid && (!r_busy || (adv && at_last));

    // Working burst and character index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (adv) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_burst <= i_q_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ochar <= r_burst.chars[r_idx];
            r_olast <= at_last;
            r_obad  <= r_burst.bad;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_char   = r_ochar;
    assign o_run_last   = r_olast;
    assign o_bad_object = r_obad;

    `QN_ASSERT_NOW(a_idx_in_burst, r_busy, r_idx <= r_burst.last_idx, "index past burst end")
    `QN_ASSERT_NOW(a_bad_is_last, r_ovalid && r_obad, r_olast && r_ochar == C_NUL,
        "error result not a lone zero")
    `QN_ASSERT_NEXT(a_last_frees, adv && at_last && !o_pop, !r_busy,
        "burst still busy after last character")

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import qn_pkg::*;

    // Unused mode code, handled by the object rules
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 30;

    // One emitted character as seen on the output channel
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       bad_object;
    } t_emitted;

    // One stimulus request; typed rows carry their own expected burst
    typedef struct packed {
        logic [1:0]      mode;
        logic [7:0]      ch;
        logic            first;
        logic            typed;
        logic [2:0]      count;
        logic [0:3][7:0] chars;
        logic            bad;
    } t_stim_row;

    localparam int DIRECTED_COUNT = 27;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // map rules, right after reset
        '{MODE_MAP, C_LBRACE, 1'b1, 1'b1, 3'd1, {C_LBRACE, C_NUL, C_NUL, C_NUL}, 1'b0},
        '{MODE_MAP, 8'h61,    1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_COLON,  1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_SPACE,  1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_LPAREN, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, 8'h62,    1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_COMMA,  1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_RPAREN, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_RBRACE, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_MAP, C_QUOTE,  1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        // byte extremes
        '{MODE_MAP, 8'hFF,    1'b1, 1'b1, 3'd1, {8'hFF, C_NUL, C_NUL, C_NUL}, 1'b0},
        '{MODE_MAP, 8'h01,    1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        // container rules
        '{MODE_CONT, C_LBRACK, 1'b1, 1'b1, 3'd1, {C_LBRACK, C_NUL, C_NUL, C_NUL}, 1'b0},
        '{MODE_CONT, 8'h78,    1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_CONT, C_COMMA,  1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_CONT, C_LPAREN, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_CONT, 8'h79,    1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_CONT, C_RPAREN, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_CONT, C_RBRACK, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        '{MODE_CONT, C_SPACE,  1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
        // object rules, quote error and latch
        '{MODE_OBJ, C_LPAREN, 1'b1, 1'b1, 3'd2, {C_LBRACK, C_QUOTE, C_NUL, C_NUL}, 1'b0},
        '{MODE_OBJ, C_COMMA,  1'b0, 1'b1, 3'd3, {C_QUOTE, C_COMMA, C_QUOTE, C_NUL}, 1'b0},
        '{MODE_OBJ, C_RBRACK, 1'b0, 1'b1, 3'd2, {C_QUOTE, C_RBRACK, C_NUL, C_NUL}, 1'b0},
        '{MODE_OBJ, C_QUOTE,  1'b0, 1'b1, 3'd1, {C_NUL, C_NUL, C_NUL, C_NUL}, 1'b1},
        '{MODE_OBJ, 8'h61,    1'b0, 1'b1, 3'd0, 32'h0, 1'b0},
        // spare mode code behaves as object rules
        '{MODE_SPARE, C_LBRACE, 1'b1, 1'b1, 3'd1, {C_LBRACE, C_NUL, C_NUL, C_NUL}, 1'b0},
        '{MODE_SPARE, C_QUOTE,  1'b0, 1'b1, 3'd1, {C_NUL, C_NUL, C_NUL, C_NUL}, 1'b1}
    };

    localparam t_flags FLAGS_CLEAR = '{skip_blanks: 1'b1, default: 1'b0};

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data = MODE_MAP;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_ch = 8'h01;
    logic       i_first_char = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_run_last;
    logic       o_bad_object;

    // Predictor state
    logic [1:0] rewrite_mode_r;
    t_flags     flags;
    logic [7:0] burst_chars[$];
    logic       burst_bad;

    t_emitted   expected_text[$];
    t_stim_row  stim_rows[$];
    logic [7:0] literal_text[$];
    logic [1:0] drive_mode = MODE_MAP;
    bit         in_calm = 1'b0;
    bit         out_calm = 1'b0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    container_text_quote_normalizer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_first_char (i_first_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_bad_object (o_bad_object)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // Predictor helpers: a burst holds at most four characters
    function automatic void put_char(input logic [7:0] b);
        if (burst_chars.size() < MAX_CHARS) begin
            burst_chars.push_back(b);
        end
    endfunction

    function automatic void close_token();
        if (flags.quote_open) begin
            put_char(C_QUOTE);
            flags.quote_open = 1'b0;
        end
    endfunction

    // Rewrites one character into burst_chars and updates the flags
    function automatic void normalize_char(input logic [7:0] c, input logic first);
        logic is_map;
        burst_chars.delete();
        burst_bad = 1'b0;
        is_map = (rewrite_mode_r == MODE_MAP);
        if (first) begin
            flags = FLAGS_CLEAR;
        end
        if (flags.error_latched || c == C_NUL) begin
            return;
        end
        if (rewrite_mode_r >= MODE_OBJ) begin
            if (c == C_QUOTE) begin
                flags.error_latched = 1'b1;
                burst_chars.push_back(C_NUL);
                burst_bad = 1'b1;
                return;
            end
            case (c)
                C_COMMA: begin
                    put_char(C_QUOTE);
                    put_char(C_COMMA);
                    put_char(C_QUOTE);
                end
                C_LPAREN, C_LBRACK: begin
                    put_char(C_LBRACK);
                    put_char(C_QUOTE);
                end
                C_RPAREN, C_RBRACK: begin
                    put_char(C_QUOTE);
                    put_char(C_RBRACK);
                end
                default: put_char(c);
            endcase
            return;
        end
        // map and container rules
        case (c)
            C_QUOTE: begin
                put_char(c);
                flags.token_pending = 1'b0;
                flags.quote_open = 1'b0;
            end
            C_COLON: begin
                close_token();
                put_char(c);
                put_char(C_SPACE);
                put_char(C_QUOTE);
                flags.quote_open = 1'b1;
                flags.skip_blanks = 1'b1;
            end
            C_COMMA: begin
                if (!(is_map && flags.paren_open)) begin
                    close_token();
                end
                put_char(c);
                flags.token_pending = 1'b1;
                flags.skip_blanks = 1'b1;
            end
            C_LPAREN: begin
                put_char(c);
                if (is_map) begin
                    flags.paren_open = 1'b1;
                end else begin
                    flags.token_pending = 1'b1;
                    flags.skip_blanks = 1'b1;
                end
            end
            C_RPAREN: begin
                if (is_map) begin
                    flags.paren_open = 1'b0;
                end else begin
                    close_token();
                end
                put_char(c);
            end
            C_LBRACK, C_LBRACE: begin
                put_char(c);
                flags.token_pending = 1'b1;
                flags.skip_blanks = 1'b1;
            end
            C_RBRACK, C_RBRACE: begin
                close_token();
                put_char(c);
            end
            C_SPACE: begin
                if (!flags.skip_blanks) begin
                    put_char(c);
                end
            end
            default: begin
                if (flags.token_pending) begin
                    if (!(is_map && flags.paren_open)) begin
                        put_char(C_QUOTE);
                    end
                    flags.token_pending = 1'b0;
                    flags.quote_open = 1'b1;
                end
                flags.skip_blanks = 1'b0;
                put_char(c);
            end
        endcase
    endfunction

    // Output check, input prediction and config tracking at each edge
    always @(posedge i_clk) begin : monitor
        t_emitted  want;
        t_stim_row row;
        if (!i_rst_n) begin
            rewrite_mode_r = MODE_MAP;
            flags = FLAGS_CLEAR;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_text.size() == 0) begin
                    flag_mismatch($sformatf("unexpected char %02h", o_out_char));
                end else begin
                    want = expected_text.pop_front();
                    if (o_out_char !== want.out_char)
                        flag_mismatch($sformatf("out_char %02h, want %02h",
                                                o_out_char, want.out_char));
                    if (o_run_last !== want.run_last)
                        flag_mismatch($sformatf("run_last %b, want %b",
                                                o_run_last, want.run_last));
                    if (o_bad_object !== want.bad_object)
                        flag_mismatch($sformatf("bad_object %b, want %b",
                                                o_bad_object, want.bad_object));
                end
            end
            if (i_valid && !o_stall) begin
                row = stim_rows.pop_front();
                normalize_char(i_ch, i_first_char);
                if (row.typed) begin
                    for (int k = 0; k < int'(row.count); k++) begin
                        expected_text.push_back('{row.chars[k], k == int'(row.count) - 1,
                                                  row.bad});
                    end
                end else begin
                    for (int k = 0; k < burst_chars.size(); k++) begin
                        expected_text.push_back('{burst_chars[k],
                                                  k == burst_chars.size() - 1, burst_bad});
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                rewrite_mode_r = i_cfg_data;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: random stall before each character, with calm stretches
    initial begin : out_pacing
        int hold;
        forever begin
            hold = out_calm ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Sends one request after a random gap and waits for it to be taken
    task automatic send_char(input t_stim_row row);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        stim_rows.push_back(row);
        i_valid <= 1'b1;
        i_ch <= row.ch;
        i_first_char <= row.first;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Waits for all characters out, lets trailing requests settle
    task automatic drain_output();
        @(posedge i_clk);
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        i_valid <= 1'b0;
        drain_output();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        drive_mode = mode;
    endtask

    function automatic t_stim_row plain_row(input logic [7:0] c, input logic first);
        return '{drive_mode, c, first, 1'b0, 3'd0, 32'h0, 1'b0};
    endfunction

    // Mostly token characters, now and then a quote or any byte
    function automatic logic [7:0] token_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return C_QUOTE;
        if (pick == 1) return 8'($urandom_range(1, 255));
        if (pick < 5) return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic void push_token();
        repeat ($urandom_range(1, 3)) literal_text.push_back(token_byte());
    endfunction

    function automatic void push_blanks();
        repeat ($urandom_range(0, 2)) literal_text.push_back(C_SPACE);
    endfunction

    // Builds a small well-formed literal such as "{a: b, (c, d)}"
    function automatic void build_literal();
        logic [7:0] closer;
        int         elems;
        literal_text.delete();
        case ($urandom_range(0, 2))
            0: begin
                literal_text.push_back(C_LBRACE);
                closer = C_RBRACE;
            end
            1: begin
                literal_text.push_back(C_LBRACK);
                closer = C_RBRACK;
            end
            default: begin
                literal_text.push_back(C_LPAREN);
                closer = C_RPAREN;
            end
        endcase
        push_blanks();
        elems = $urandom_range(1, 3);
        for (int e = 0; e < elems; e++) begin
            if (e > 0) begin
                literal_text.push_back(C_COMMA);
                push_blanks();
            end
            case ($urandom_range(0, 3))
                0: push_token();
                1: begin
                    push_token();
                    literal_text.push_back(C_COLON);
                    push_blanks();
                    push_token();
                end
                2: begin
                    literal_text.push_back(C_LPAREN);
                    push_token();
                    literal_text.push_back(C_COMMA);
                    push_blanks();
                    push_token();
                    literal_text.push_back(C_RPAREN);
                end
                default: begin
                    literal_text.push_back(C_LBRACK);
                    push_token();
                    literal_text.push_back(C_RBRACK);
                end
            endcase
        end
        push_blanks();
        literal_text.push_back(closer);
    endfunction

    // Main sequence
    initial begin : stimulus
        int sent;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (DIRECTED_ROWS[i].mode != drive_mode) set_mode(DIRECTED_ROWS[i].mode);
            send_char(DIRECTED_ROWS[i]);
        end

        // random phases: every mode code first, then random ones
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_mode(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) begin
                    build_literal();
                    foreach (literal_text[k]) send_char(plain_row(literal_text[k], k == 0));
                    sent += literal_text.size();
                end else begin
                    // noise: arbitrary bytes, markers at random
                    repeat ($urandom_range(1, 5)) begin
                        send_char(plain_row(8'($urandom_range(1, 255)),
                                            $urandom_range(0, 3) == 0));
                        sent++;
                    end
                end
            end
        end

        i_valid <= 1'b0;
        drain_output();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qn_pkg.sv
rtl/qn_front.sv
rtl/qn_queue.sv
rtl/qn_back.sv
rtl/container_text_quote_normalizer.sv
sim/tb.sv
